### src/tcpg_pkg.sv
// shared types, constants and helper functions of the pulse train generator
// no dependencies

package tcpg_pkg;

   localparam int COMMAND_LENGTH        = 12;
   localparam int TICKS_PER_MILLISECOND = 1000;
   localparam int TICKS_PER_SECOND      = 1000000;

   localparam int POS_W      = $clog2(COMMAND_LENGTH + 1);
   localparam int LEN_W      = 10;
   localparam int COUNT_W    = 7;
   localparam int PRESCALE_W = $clog2(TICKS_PER_SECOND + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // character codes
   localparam logic [7:0] CHAR_GO    = 8'h47;  // 'G'
   localparam logic [7:0] CHAR_QUERY = 8'h3F;  // '?'
   localparam logic [7:0] CHAR_SEP   = 8'h73;  // 's'
   localparam logic [7:0] CHAR_SPACE = 8'h20;  // ' '
   localparam logic [7:0] CHAR_MILLI = 8'h6D;  // 'm'
   localparam logic [7:0] CHAR_MICRO = 8'h75;  // 'u'
   localparam logic [7:0] CHAR_CR    = 8'h0D;  // carriage return
   localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'

   typedef enum logic [1:0] {
      STATUS_NONE   = 2'd0,
      STATUS_ACCEPT = 2'd1,
      STATUS_REJECT = 2'd2,
      STATUS_QUERY  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      UNIT_SEC  = 2'd0,
      UNIT_MSEC = 2'd1,
      UNIT_USEC = 2'd2
   } unit_type;

   // what the back end has to do with one word
   typedef enum logic [3:0] {
      EV_TICK = 4'b0001,  // advance the train by one microsecond
      EV_CHAR = 4'b0010,  // character with no effect on the train
      EV_LOAD = 4'b0100,  // valid command, restart the train
      EV_STOP = 4'b1000   // bad unit, stop the train
   } event_kind_type;

   typedef struct packed {
      event_kind_type     kind;
      status_type         status;
      logic [LEN_W-1:0]   high_length;
      logic [LEN_W-1:0]   low_length;
      unit_type           high_unit;
      unit_type           low_unit;
      logic [COUNT_W-1:0] pulses_wanted;
   } event_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   function automatic logic [PRESCALE_W-1:0] ticks_per_unit(input unit_type u);
      logic [PRESCALE_W-1:0] t;
      unique case (u)
         UNIT_SEC:  t = PRESCALE_W'(TICKS_PER_SECOND);
         UNIT_MSEC: t = PRESCALE_W'(TICKS_PER_MILLISECOND);
         default:   t = PRESCALE_W'(1);
      endcase
      return t;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic [3:0] digit_value(input logic [7:0] c);
      return 4'(c - CHAR_ZERO);
   endfunction

endpackage

### src/tcpg_if.sv
// valid/ready channel interfaces for the request and response sides
// no dependencies

interface tcpg_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] char_code;

   modport source (output valid, output command, output char_code, input ready);
   modport sink   (input valid, input command, input char_code, output ready);
endinterface

interface tcpg_rsp_if;
   logic       valid;
   logic       ready;
   logic       pulse_out;
   logic [1:0] status;
   logic       train_busy;

   modport source (output valid, output pulse_out, output status, output train_busy,
                   input ready);
   modport sink   (input valid, input pulse_out, input status, input train_busy,
                   output ready);
endinterface

### src/tcpg_front.sv
// front end: collects command characters and turns each word into a train event
// depends on tcpg_pkg and tcpg_req_if

module tcpg_front
   import tcpg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   tcpg_req_if.sink       req,
   input  queue_stat_type qstat,
   output logic           push,
   output event_type      push_data
);

   logic [7:0]       store_ff [COMMAND_LENGTH];
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic             store_we;

   logic digits_ok;
   logic seps_ok;
   logic units_ok;
   unit_type hu;
   unit_type lu;

   assign req.ready = !qstat.full;
   assign push      = req.valid && req.ready;

   // command field checks on the stored characters
   always_comb begin
      digits_ok = is_digit(store_ff[0]) && is_digit(store_ff[1]) && is_digit(store_ff[2])
               && is_digit(store_ff[5]) && is_digit(store_ff[6]) && is_digit(store_ff[7])
               && is_digit(store_ff[10]) && is_digit(store_ff[11]);
      seps_ok   = (store_ff[4] == CHAR_SEP) && (store_ff[9] == CHAR_SEP);
      units_ok  = 1'b1;
      hu        = UNIT_SEC;
      lu        = UNIT_SEC;
      unique case (store_ff[3])
         CHAR_SPACE: hu = UNIT_SEC;
         CHAR_MILLI: hu = UNIT_MSEC;
         CHAR_MICRO: hu = UNIT_USEC;
         default:    units_ok = 1'b0;
      endcase
      unique case (store_ff[8])
         CHAR_SPACE: lu = UNIT_SEC;
         CHAR_MILLI: lu = UNIT_MSEC;
         CHAR_MICRO: lu = UNIT_USEC;
         default:    units_ok = 1'b0;
      endcase
   end

   always_comb begin
      pos_in                  = pos_ff;
      store_we                = 1'b0;
      push_data.kind          = EV_CHAR;
      push_data.status        = STATUS_NONE;
      push_data.high_unit     = hu;
      push_data.low_unit      = lu;
      push_data.high_length   = 10'(digit_value(store_ff[0])) * 10'd100
                              + 10'(digit_value(store_ff[1])) * 10'd10
                              + 10'(digit_value(store_ff[2]));
      push_data.low_length    = 10'(digit_value(store_ff[5])) * 10'd100
                              + 10'(digit_value(store_ff[6])) * 10'd10
                              + 10'(digit_value(store_ff[7]));
      push_data.pulses_wanted = 7'(digit_value(store_ff[10])) * 7'd10
                              + 7'(digit_value(store_ff[11]));
      if (req.command) begin
         push_data.kind = EV_TICK;
      end else if (req.char_code == CHAR_CR) begin
         push_data.kind = EV_CHAR;
      end else if (req.char_code == CHAR_QUERY) begin
         pos_in           = '0;
         push_data.status = STATUS_QUERY;
      end else if (req.char_code == CHAR_GO) begin
         pos_in           = '0;
         push_data.status = STATUS_REJECT;
         if (pos_ff == POS_W'(COMMAND_LENGTH) && digits_ok && seps_ok) begin
            if (units_ok) begin
               push_data.kind   = EV_LOAD;
               push_data.status = STATUS_ACCEPT;
            end else begin
               push_data.kind   = EV_STOP;
            end
         end
      end else if (pos_ff >= POS_W'(COMMAND_LENGTH)) begin
         // one character too many
         pos_in           = '0;
         push_data.status = STATUS_REJECT;
      end else begin
         store_we = 1'b1;
         pos_in   = pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (push) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && store_we) begin
         store_ff[pos_ff] <= req.char_code;
      end
   end

endmodule

### src/tcpg_queue.sv
// short event queue between the front end and the train engine
// depends on tcpg_pkg

module tcpg_queue
   import tcpg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  event_type      push_data,
   input  logic           pop,
   output event_type      pop_data,
   output queue_stat_type qstat
);

   event_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff;
   logic [QUEUE_AW-1:0]   rd_ptr_ff;
   logic [QUEUE_CW-1:0]   count_ff;

   function automatic logic [QUEUE_AW-1:0] next_ptr(input logic [QUEUE_AW-1:0] p);
      return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_AW'(1);
   endfunction

   assign qstat.full  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign pop_data    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QUEUE_CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QUEUE_CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/tcpg_back.sv
// back end: pulse train engine and response register
// depends on tcpg_pkg and tcpg_rsp_if

module tcpg_back
   import tcpg_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      ev_valid,
   input  event_type ev,
   output logic      pop,
   tcpg_rsp_if.source rsp
);

   logic [LEN_W-1:0]      high_length_ff, high_length_in;
   logic [LEN_W-1:0]      low_length_ff, low_length_in;
   unit_type              high_unit_ff, high_unit_in;
   unit_type              low_unit_ff, low_unit_in;
   logic [COUNT_W-1:0]    wanted_ff, wanted_in;
   logic [COUNT_W-1:0]    done_ff, done_in;
   logic                  active_ff, active_in;
   logic                  low_phase_ff, low_phase_in;
   logic [LEN_W-1:0]      units_ff, units_in;
   logic [PRESCALE_W-1:0] prescale_ff, prescale_in;

   logic       rsp_valid_ff;
   logic       pulse_ff;
   status_type status_ff;
   logic       busy_ff;

   logic                  phase_end;
   logic                  do_skip;
   logic [PRESCALE_W:0]   prescale_inc;
   logic [LEN_W:0]        units_inc;
   logic [LEN_W-1:0]      len_cur;
   unit_type              unit_cur;
   logic                  high_zero;
   logic                  low_zero;

   assign pop = ev_valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      high_length_in = high_length_ff;
      low_length_in  = low_length_ff;
      high_unit_in   = high_unit_ff;
      low_unit_in    = low_unit_ff;
      wanted_in      = wanted_ff;
      done_in        = done_ff;
      active_in      = active_ff;
      low_phase_in   = low_phase_ff;
      units_in       = units_ff;
      prescale_in    = prescale_ff;
      phase_end      = 1'b0;
      do_skip        = 1'b0;
      len_cur        = low_phase_ff ? low_length_ff : high_length_ff;
      unit_cur       = low_phase_ff ? low_unit_ff : high_unit_ff;
      prescale_inc   = {1'b0, prescale_ff} + (PRESCALE_W+1)'(1);
      units_inc      = {1'b0, units_ff} + (LEN_W+1)'(1);

      unique case (ev.kind)
         EV_TICK: begin
            if (active_ff) begin
               if (prescale_inc < {1'b0, ticks_per_unit(unit_cur)}) begin
                  prescale_in = prescale_inc[PRESCALE_W-1:0];
               end else begin
                  prescale_in = '0;
                  if (units_inc < {1'b0, len_cur}) begin
                     units_in = units_inc[LEN_W-1:0];
                  end else begin
                     units_in  = '0;
                     phase_end = 1'b1;
                     do_skip   = 1'b1;
                  end
               end
            end
         end
         EV_LOAD: begin
            high_length_in = ev.high_length;
            low_length_in  = ev.low_length;
            high_unit_in   = ev.high_unit;
            low_unit_in    = ev.low_unit;
            wanted_in      = ev.pulses_wanted;
            done_in        = '0;
            active_in      = (ev.pulses_wanted != '0);
            low_phase_in   = 1'b0;
            units_in       = '0;
            prescale_in    = '0;
            do_skip        = 1'b1;
         end
         EV_STOP: begin
            done_in      = '0;
            active_in    = 1'b0;
            low_phase_in = 1'b0;
            units_in     = '0;
            prescale_in  = '0;
         end
         default: begin
         end
      endcase

      // a finished high phase moves to low, a finished low phase ends the pulse
      if (phase_end) begin
         if (!low_phase_in) begin
            low_phase_in = 1'b1;
         end else begin
            done_in      = done_in + COUNT_W'(1);
            low_phase_in = 1'b0;
            if (done_in >= wanted_in) active_in = 1'b0;
         end
      end

      // skip zero-length phases; with both lengths zero the whole train completes
      high_zero = (high_length_in == '0);
      low_zero  = (low_length_in == '0);
      if (do_skip) begin
         if (active_in && !low_phase_in && high_zero) begin
            low_phase_in = 1'b1;
         end
         if (active_in && low_phase_in && low_zero) begin
            done_in      = done_in + COUNT_W'(1);
            low_phase_in = 1'b0;
            if (done_in >= wanted_in) active_in = 1'b0;
         end
         if (active_in && high_zero && low_zero) begin
            done_in   = wanted_in;
            active_in = 1'b0;
         end
         if (!active_in) low_phase_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_length_ff <= '0;
         low_length_ff  <= '0;
         high_unit_ff   <= UNIT_SEC;
         low_unit_ff    <= UNIT_SEC;
         wanted_ff      <= '0;
         done_ff        <= '0;
         active_ff      <= 1'b0;
         low_phase_ff   <= 1'b0;
         units_ff       <= '0;
         prescale_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (pop) begin
            high_length_ff <= high_length_in;
            low_length_ff  <= low_length_in;
            high_unit_ff   <= high_unit_in;
            low_unit_ff    <= low_unit_in;
            wanted_ff      <= wanted_in;
            done_ff        <= done_in;
            active_ff      <= active_in;
            low_phase_ff   <= low_phase_in;
            units_ff       <= units_in;
            prescale_ff    <= prescale_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         pulse_ff  <= active_in && !low_phase_in;
         status_ff <= ev.status;
         busy_ff   <= active_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.pulse_out  = pulse_ff;
   assign rsp.status     = status_ff;
   assign rsp.train_busy = busy_ff;

endmodule

### src/text_commanded_pulse_train_generator_unit.sv
// text commanded pulse train generator, top level
// an accepted word is held in the event queue, then stepped by the train engine into the
//   response register, from which it is offered
// throughput: one word per cycle while the response side takes each word
// reset: synchronous, active high; clears the command position, idles the train, empties
//   the event queue and drops the response valid

module text_commanded_pulse_train_generator_unit
   import tcpg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tcpg_req_if.sink    req_if,
   tcpg_rsp_if.source  rsp_if
);

   // front end to queue
   logic           push;
   event_type      push_data;
   queue_stat_type qstat;

   // queue to back end
   logic           pop;
   event_type      pop_data;

   // character collection and command decode; ready follows the queue having room,
   // so a word is taken even while a response still waits downstream
   tcpg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .qstat     (qstat),
      .push      (push),
      .push_data (push_data)
   );

   // two-entry queue lets the front keep taking words while the response side stalls
   tcpg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   // train engine: one event per cycle into the response register while the response is taken
   tcpg_back u_back (
      .clock    (clock),
      .reset    (reset),
      .ev_valid (!qstat.empty),
      .ev       (pop_data),
      .pop      (pop),
      .rsp      (rsp_if)
   );

endmodule

### src/tcpg_checker.sv
// port-level checks on the pulse train generator response side
// depends on the top level module, bound to it below

module tcpg_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_pulse_out,
   input logic [1:0] rsp_status,
   input logic       rsp_train_busy
);

   // a stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_pulse_out) && $stable(rsp_train_busy))
      else $error("stalled response changed");

   // the pin is only high while a train runs
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pulse_out |-> rsp_train_busy)
      else $error("pulse high with no train running");

   // nothing is offered right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind text_commanded_pulse_train_generator_unit tcpg_checker u_tcpg_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_pulse_out  (rsp_if.pulse_out),
   .rsp_status     (rsp_if.status),
   .rsp_train_busy (rsp_if.train_busy)
);
